### rtl/csac_pkg.sv
// ============================================================================
// csac_pkg
// Types and constants shared by the private cache tag and state arrays.
// ============================================================================
`default_nettype none

package csac_pkg;

  localparam int CORE_COUNT   = 4;
  localparam int SET_COUNT    = 64;
  localparam int WAY_COUNT    = 4;
  localparam int OFFSET_BITS  = 6;
  localparam int ADDRESS_BITS = 48;

  localparam int CORE_W  = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
  localparam int SET_W   = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_W   = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int ROWS    = CORE_COUNT * SET_COUNT;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TAG_W   = ADDRESS_BITS - OFFSET_BITS;
  localparam int STAMP_W = 64;

  typedef enum logic [1:0] {
    OP_READ       = 2'd0,
    OP_WRITE      = 2'd1,
    OP_INVALIDATE = 2'd2,
    OP_DOWNGRADE  = 2'd3
  } op_t;

  localparam logic [1:0] ST_INVALID = 2'd0;
  localparam logic [1:0] ST_SHARED  = 2'd1;
  localparam logic [1:0] ST_EXCL    = 2'd2;

  localparam logic [1:0] REQ_NONE   = 2'd0;
  localparam logic [1:0] REQ_SHARED = 2'd1;
  localparam logic [1:0] REQ_EXCL   = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  core;
    logic [47:0] address;
    logic        grant_exclusive;
  } request_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  dir_request;
    logic        evict_valid;
    logic [47:0] evict_block;
    logic [1:0]  way_used;
    logic [1:0]  line_state_out;
  } result_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [1:0]         state;
    logic [STAMP_W-1:0] stamp;
  } way_t;

  typedef way_t [WAY_COUNT-1:0] row_t;

endpackage

`default_nettype wire

### rtl/coherent_set_assoc_cache_lru.sv
// ============================================================================
// coherent_set_assoc_cache_lru
// Private set-associative caches with MSI-like line states and LRU by stamps.
// ============================================================================
//  channel | signals                   | timing
//  request | start, busy, req          | taken when start and not busy
//  result  | done, res                 | one cycle strobe, cannot stall
//
//  A request passes three steps from acceptance to the next possible
//  acceptance: row read from the memory, decision and write back, then the
//  result strobe. Busy is high during the row read and the decision; a new
//  request can be taken in the strobe cycle.
//  After reset a clearing pass writes every row of the memory, one per cycle,
//  all CORE_COUNT*SET_COUNT rows (256 here), with busy held high.
//  The receiver cannot stall, so results are never held back.
`default_nettype none

module coherent_set_assoc_cache_lru (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  csac_pkg::request_t      req,
  output logic                    busy,
  output logic                    done,
  output csac_pkg::result_t       res
);
  import csac_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_WRITE} fsm_t;

  fsm_t fsm;
  logic [ROW_W:0] clr_cnt;
  row_t mem [ROWS];
  row_t rd_row;
  request_t cur;
  logic [63:0] access_clock;
  logic [TAG_W-1:0] cur_tag;
  logic [SET_W-1:0] cur_set;
  logic core_ok;
  logic [ROW_W-1:0] row_addr;

  assign cur_tag = cur.address[ADDRESS_BITS-1:OFFSET_BITS];
  assign cur_set = SET_W'(cur_tag % SET_COUNT);
  assign core_ok = 32'(cur.core) < CORE_COUNT;
  assign row_addr = ROW_W'(32'(cur.core) * SET_COUNT + 32'(cur_set));
  assign busy = (fsm != S_IDLE);

  logic             match_f, inv_f;
  logic [WAY_W-1:0] match_w, inv_w, old_w, vic_w, use_w;
  row_t             new_row;
  result_t          r_next;
  logic             adv;

  always_comb begin
    match_f = 1'b0; match_w = '0; inv_f = 1'b0; inv_w = '0; old_w = '0;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (rd_row[w].state != ST_INVALID && rd_row[w].tag == cur_tag) begin
        match_f = 1'b1; match_w = WAY_W'(w);
      end
      if (rd_row[w].state == ST_INVALID) begin
        inv_f = 1'b1; inv_w = WAY_W'(w);
      end
    end
    for (int w = 1; w < WAY_COUNT; w++) begin
      if (rd_row[w].stamp < rd_row[old_w].stamp) old_w = WAY_W'(w);
    end
    vic_w = inv_f ? inv_w : old_w;
    new_row = rd_row;
    r_next = '0;
    adv = 1'b0;
    use_w = match_w;
    if (core_ok) begin
      if (cur.operation == OP_READ || cur.operation == OP_WRITE) begin
        adv = 1'b1;
        if (match_f && (cur.operation == OP_READ || rd_row[match_w].state == ST_EXCL)) begin
          r_next.hit = 1'b1;
        end else begin
          r_next.dir_request = (cur.operation == OP_READ) ? REQ_SHARED : REQ_EXCL;
          use_w = (cur.operation == OP_WRITE && match_f) ? match_w : vic_w;
          if (rd_row[use_w].state != ST_INVALID && rd_row[use_w].tag != cur_tag) begin
            r_next.evict_valid = 1'b1;
            r_next.evict_block = 48'({rd_row[use_w].tag, {OFFSET_BITS{1'b0}}});
          end
          new_row[use_w].tag = cur_tag;
          new_row[use_w].state = (cur.operation == OP_WRITE || cur.grant_exclusive)
                                 ? ST_EXCL : ST_SHARED;
        end
        new_row[use_w].stamp = access_clock + 64'd1;
        r_next.way_used = 2'(use_w);
        r_next.line_state_out = new_row[use_w].state;
      end else if (match_f) begin
        new_row[match_w].state = (cur.operation == OP_INVALIDATE) ? ST_INVALID : ST_SHARED;
        r_next.hit = 1'b1;
        r_next.way_used = 2'(match_w);
        r_next.line_state_out = new_row[match_w].state;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fsm == S_CLEAR) begin
      mem[clr_cnt[ROW_W-1:0]] <= '0;
    end else if (fsm == S_WRITE) begin
      mem[row_addr] <= new_row;
    end
    rd_row <= mem[row_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= S_CLEAR;
      clr_cnt <= '0;
      access_clock <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (fsm)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (ROW_W+1)'(ROWS - 1)) fsm <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            cur <= req;
            fsm <= S_READ;
          end
        end
        S_READ: fsm <= S_WRITE;
        S_WRITE: begin
          if (adv) access_clock <= access_clock + 64'd1;
          res <= r_next;
          done <= 1'b1;
          fsm <= S_IDLE;
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/csac_checker.sv
// ============================================================================
// csac_checker
// Port-level checks for the private cache arrays.
// ============================================================================
`default_nettype none

module csac_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done,
  input csac_pkg::result_t  res
);
  import csac_pkg::*;

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after request");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_done_implies_free: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy during result strobe");
  a_hit_no_req: assert property (@(posedge clk) disable iff (rst)
    done && res.hit |-> res.dir_request == REQ_NONE && !res.evict_valid)
    else $error("hit with directory request or eviction");
  a_evict_req: assert property (@(posedge clk) disable iff (rst)
    done && res.evict_valid |-> res.dir_request != REQ_NONE)
    else $error("eviction without directory request");

endmodule

bind coherent_set_assoc_cache_lru csac_checker u_csac_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .res(res)
);

`default_nettype wire

### sim/tb_coherent_set_assoc_cache_lru.sv
// ============================================================================
// tb_coherent_set_assoc_cache_lru
// Self-checking bench for the private cache tag and state arrays. A behavioral
// model of the per-core sets predicts every result, which is compared field by
// field as the done strobe arrives.
// ============================================================================
`default_nettype none

module tb_coherent_set_assoc_cache_lru;
  timeunit 1ns;
  timeprecision 1ps;

  import csac_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  request_t req = '0;
  logic busy;
  logic done;
  result_t res;

  coherent_set_assoc_cache_lru dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .res(res)
  );

  always #1 clk = ~clk;

  logic [TAG_W-1:0] m_tag [CORE_COUNT][SET_COUNT][WAY_COUNT];
  logic [1:0] m_state [CORE_COUNT][SET_COUNT][WAY_COUNT];
  logic [63:0] m_stamp [CORE_COUNT][SET_COUNT][WAY_COUNT];
  logic [63:0] m_clock;

  result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit gaps_on = 1'b1;

  localparam int CYCLE_LIMIT = 200000;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic result_t cache_access(input request_t r);
    result_t o;
    logic [TAG_W-1:0] tag;
    int s, m, w, c;
    o = '0;
    c = int'(r.core);
    tag = r.address[47:OFFSET_BITS];
    s = int'(tag % SET_COUNT);
    if (c >= CORE_COUNT) return o;
    m = -1;
    for (int i = WAY_COUNT - 1; i >= 0; i--)
      if (m_state[c][s][i] != ST_INVALID && m_tag[c][s][i] == tag) m = i;
    if (r.operation == OP_READ || r.operation == OP_WRITE) begin
      m_clock++;
      if (m >= 0 && (r.operation == OP_READ || m_state[c][s][m] == ST_EXCL)) begin
        o.hit = 1'b1;
        w = m;
      end else begin
        o.dir_request = (r.operation == OP_READ) ? REQ_SHARED : REQ_EXCL;
        if (r.operation == OP_WRITE && m >= 0) begin
          w = m;
        end else begin
          w = -1;
          for (int i = WAY_COUNT - 1; i >= 0; i--)
            if (m_state[c][s][i] == ST_INVALID) w = i;
          if (w < 0) begin
            w = 0;
            for (int i = 1; i < WAY_COUNT; i++)
              if (m_stamp[c][s][i] < m_stamp[c][s][w]) w = i;
          end
        end
        if (m_state[c][s][w] != ST_INVALID && m_tag[c][s][w] != tag) begin
          o.evict_valid = 1'b1;
          o.evict_block = {m_tag[c][s][w], {OFFSET_BITS{1'b0}}};
        end
        m_tag[c][s][w] = tag;
        m_state[c][s][w] = (r.operation == OP_WRITE || r.grant_exclusive) ? ST_EXCL : ST_SHARED;
      end
      m_stamp[c][s][w] = m_clock;
      o.way_used = w[1:0];
      o.line_state_out = m_state[c][s][w];
    end else if (m >= 0) begin
      m_state[c][s][m] = (r.operation == OP_INVALIDATE) ? ST_INVALID : ST_SHARED;
      o.hit = 1'b1;
      o.way_used = m[1:0];
      o.line_state_out = m_state[c][s][m];
    end
    return o;
  endfunction

  task automatic send_request(input request_t r);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(cache_access(r));
  endtask

  always @(posedge clk) begin
    result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 64'(res), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (res.hit !== want.hit) report("hit", 64'(res.hit), 64'(want.hit));
        if (res.dir_request !== want.dir_request)
          report("dir_request", 64'(res.dir_request), 64'(want.dir_request));
        if (res.evict_valid !== want.evict_valid)
          report("evict_valid", 64'(res.evict_valid), 64'(want.evict_valid));
        if (res.evict_block !== want.evict_block)
          report("evict_block", 64'(res.evict_block), 64'(want.evict_block));
        if (res.way_used !== want.way_used)
          report("way_used", 64'(res.way_used), 64'(want.way_used));
        if (res.line_state_out !== want.line_state_out)
          report("line_state_out", 64'(res.line_state_out), 64'(want.line_state_out));
      end
    end
  end

  function automatic request_t make_req(input logic [1:0] op, input logic [1:0] c,
                                        input logic [47:0] a, input logic g);
    request_t r;
    r.operation = op;
    r.core = c;
    r.address = a;
    r.grant_exclusive = g;
    return r;
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [47:0] base;
    base = 48'h0000_0000_1040;
    send_request(make_req(OP_READ, 2'd0, 48'h0, 1'b0));
    send_request(make_req(OP_READ, 2'd0, 48'h3f, 1'b0));
    send_request(make_req(OP_WRITE, 2'd0, 48'h0, 1'b0));
    send_request(make_req(OP_WRITE, 2'd0, 48'h0, 1'b1));
    send_request(make_req(OP_DOWNGRADE, 2'd0, 48'h0, 1'b0));
    send_request(make_req(OP_INVALIDATE, 2'd0, 48'h0, 1'b0));
    send_request(make_req(OP_INVALIDATE, 2'd1, 48'h0, 1'b0));
    send_request(make_req(OP_DOWNGRADE, 2'd1, 48'h0, 1'b0));
    send_request(make_req(OP_READ, 2'd3, 48'hffff_ffff_ffff, 1'b1));
    send_request(make_req(OP_WRITE, 2'd3, 48'hffff_ffff_ffff, 1'b0));
    for (int i = 0; i < 6; i++)
      send_request(make_req(OP_READ, 2'd2, base + 48'(i) * 48'h1000, i[0]));
    send_request(make_req(OP_READ, 2'd2, base + 48'h1000, 1'b0));
    send_request(make_req(OP_WRITE, 2'd2, base + 48'h7000, 1'b0));
    send_request(make_req(OP_WRITE, 2'd2, base + 48'h1000, 1'b0));
    send_request(make_req(OP_READ, 2'd1, 48'haaaa_aaaa_aaaa, 1'b1));
    send_request(make_req(OP_READ, 2'd1, 48'h5555_5555_5555, 1'b0));
    wait_drained();
  endtask

  task automatic test_random(input int count);
    request_t r;
    logic [47:0] pool [16];
    for (int i = 0; i < 16; i++)
      pool[i] = 48'({$urandom, $urandom});
    for (int i = 0; i < count; i++) begin
      if (i == count - 300) gaps_on = 1'b0;
      r.operation = 2'($urandom_range(0, 3));
      r.core = 2'($urandom_range(0, 3));
      r.grant_exclusive = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: r.address = 48'({$urandom, $urandom});
        1, 2, 3: r.address = pool[$urandom_range(0, 15)];
        default: r.address = (48'($urandom_range(0, 7)) << 12)
                             | 48'($urandom_range(0, 63))
                             | (48'($urandom_range(0, 3)) << 6);
      endcase
      send_request(r);
      if (i == count / 2) wait_drained();
    end
  endtask

  initial begin
    for (int c = 0; c < CORE_COUNT; c++)
      for (int s = 0; s < SET_COUNT; s++)
        for (int w = 0; w < WAY_COUNT; w++) begin
          m_tag[c][s][w] = '0;
          m_state[c][s][w] = ST_INVALID;
          m_stamp[c][s][w] = '0;
        end
    m_clock = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(2000);
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
